@@ rtl/kts_pkg.sv @@
// kts_pkg: shared codes, controller/datapath command and status types, and the
// quarter-wave sine table used by the easing curves of the key track sampler.
// No dependencies.
package kts_pkg;

	// Operation codes
	localparam logic [2:0] OP_INSERT   = 3'd0;
	localparam logic [2:0] OP_REMOVE   = 3'd1;
	localparam logic [2:0] OP_SET      = 3'd2;
	localparam logic [2:0] OP_GET      = 3'd3;
	localparam logic [2:0] OP_EVALUATE = 3'd4;
	localparam logic [2:0] OP_CLEAR    = 3'd5;

	// Status codes
	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND    = 3'd1;
	localparam logic [2:0] ST_FULL         = 3'd2;
	localparam logic [2:0] ST_DUPLICATE    = 3'd3;
	localparam logic [2:0] ST_BAD_CURVE    = 3'd4;
	localparam logic [2:0] ST_OUT_OF_RANGE = 3'd5;

	// Easing curve codes
	localparam logic [3:0] CRV_LINEAR = 4'd0;
	localparam logic [3:0] CRV_SIN1   = 4'd1;
	localparam logic [3:0] CRV_SIN2   = 4'd2;
	localparam logic [3:0] CRV_SIN3   = 4'd3;
	localparam logic [3:0] CRV_SIN4   = 4'd4;
	localparam logic [3:0] CRV_COS1   = 4'd5;
	localparam logic [3:0] CRV_COS2   = 4'd6;
	localparam logic [3:0] CRV_COS3   = 4'd7;
	localparam logic [3:0] CRV_COS4   = 4'd8;
	localparam logic [3:0] CRV_TAN    = 4'd9;

	// Sine table: CURVE_N + 1 entries over a quarter wave, Q1.16
	localparam int CURVE_N = 256;
	localparam int SIN_IW  = $clog2(CURVE_N + 1);
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// Taylor term denominators (2k)(2k+1) for k = 1..10
	localparam longint unsigned TAYLOR_DEN [1:10] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
		64'd156, 64'd210, 64'd272, 64'd342, 64'd420
	};

	typedef logic [16:0] sine_tab_t [0:CURVE_N];

	// Taylor series in Q2.30, x plus ten further terms, rounded half up to Q1.16
	function automatic sine_tab_t sine_table();
		sine_tab_t tab;
		longint unsigned x;
		longint unsigned term;
		longint sum;
		for (int i = 0; i <= CURVE_N; i++) begin
			x = (HALF_PI_Q30 * longint'(i)) / CURVE_N;
			term = x;
			sum = longint'(x);
			for (int k = 1; k <= 10; k++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / TAYLOR_DEN[k];
				if ((k % 2) == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			tab[i] = 17'((longint'(sum) + 8192) >>> 14);
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = sine_table();

	// Memory read address select
	typedef enum logic [2:0] {
		RD_IDX, RD_IDX1, RD_HI1, RD_LO, RD_LO1, RD_MID, RD_LAST, RD_ZERO
	} rdsel_t;

	// Memory write select
	typedef enum logic [1:0] {
		WR_NEW, WR_SHIFT_HI, WR_SHIFT_IDX, WR_SET
	} wrsel_t;

	// Result select
	typedef enum logic [3:0] {
		RES_OK, RES_NOT_FOUND, RES_FULL, RES_DUP, RES_BAD, RES_OOR,
		RES_GET, RES_HOLD, RES_LERP, RES_SET
	} res_t;

	// Controller states
	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_SCAN_ADDR, S_SCAN_CMP, S_ACT,
		S_SHU_RD, S_SHU_WR, S_SHD_RD, S_SHD_WR,
		S_EV_FIRST_CHK, S_EV_LAST_CHK, S_BS_ADDR, S_BS_CMP,
		S_EV_GOT0, S_EV_GOT1, S_EV_DIVS, S_EV_DIV, S_EV_SHAPE, S_EV_TDIV,
		S_EV_MUL, S_EV_FIN
	} state_t;

	typedef struct packed {
		logic   load;
		logic   rd_en;
		rdsel_t rd_sel;
		logic   idx_inc;
		logic   hi_from_count;
		logic   hi_dec;
		logic   wr_en;
		wrsel_t wr_sel;
		logic   cnt_inc;
		logic   cnt_dec;
		logic   cnt_clr;
		logic   scan_cmp;
		logic   bs_init;
		logic   bs_step;
		logic   k0_load;
		logic   k1_load;
		logic   div_t;
		logic   div_tan;
		logic   t_load;
		logic   s_load;
		logic   mul_load;
		logic   res_en;
		res_t   res_sel;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic cnt_full;
		logic crv_bad;
		logic cnt_zero;
		logic idx_at_count;
		logic scan_stop;
		logic hit;
		logic hi_eq_idx;
		logic shd_end;
		logic ik_before;
		logic ik_after;
		logic lo_eq_hi;
		logic lo_is_last;
		logic c0_bad;
		logic div_busy;
		logic tan_curve;
	} sts_t;

endpackage

@@ rtl/kts_div.sv @@
// kts_div: restoring divider, one quotient bit per cycle.
// Uses no package.
module kts_div #(
	parameter int NW = 34,
	parameter int DW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic [NW-1:0] quo
);

	localparam int CNTW = $clog2(NW);

	logic            run_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   den_q;
	logic [NW-1:0]   quo_q;
	logic [DW:0]     trial;

	// trial subtract of the divisor from the shifted remainder
	assign trial = {rem_q, quo_q[NW-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= CNTW'(NW - 1);
		end else if (run_q) begin
			if (cnt_q == '0) begin
				run_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (run_q) begin
			if (!trial[DW]) begin
				rem_q <= trial[DW-1:0];
			end else begin
				rem_q <= {rem_q[DW-2:0], quo_q[NW-1]};
			end
			quo_q <= {quo_q[NW-2:0], ~trial[DW]};
		end
	end

	assign busy = run_q;
	assign quo  = quo_q;

endmodule

@@ rtl/kts_datapath.sv @@
// kts_datapath: key memory, counters, search pointers, interpolation math and
// result registers. Depends on kts_pkg and kts_div.
module kts_datapath
	import kts_pkg::*;
#(
	parameter int DEPTH      = 64,
	parameter int FRAME_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [2:0]         operation,
	input  logic [31:0]        frame_time,
	input  logic signed [31:0] value,
	input  logic [3:0]         curve,
	input  logic [1:0]         write_mask,
	input  logic               cfg_wr_en,
	input  logic [6:0]         cfg_wr_data,
	output logic               done,
	output logic [2:0]         status,
	output logic signed [31:0] result_value,
	output logic [3:0]         result_curve,
	output logic [6:0]         key_count
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int EW   = FRAME_BITS + 36;
	localparam int CMPW = (FRAME_BITS > 17) ? FRAME_BITS : 17;
	localparam int BW   = (FRAME_BITS + 16 > 32) ? FRAME_BITS + 16 : 32;
	localparam int DW   = (FRAME_BITS > 17) ? FRAME_BITS : 17;
	localparam int NW   = 34;

	// latched item
	logic [2:0]  op_q;
	logic [31:0] time_q;
	logic [31:0] val_q;
	logic [3:0]  crv_q;
	logic [1:0]  msk_q;

	// control registers
	logic [CW-1:0] count_q;
	logic [6:0]    cap_q;
	logic          done_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] hi_q;
	logic [CW-1:0] lo_q;
	logic          hit_q;

	// key memory
	logic [EW-1:0] mem [0:DEPTH-1];
	logic [EW-1:0] rd_q;
	logic [CW-1:0] rd_addr_c;
	logic [CW-1:0] wr_addr_c;
	logic [EW-1:0] wr_data;

	// evaluate path registers
	logic [FRAME_BITS-1:0] f0_q;
	logic [FRAME_BITS-1:0] f1_q;
	logic [31:0]           v0_q;
	logic [31:0]           v1_q;
	logic [3:0]            c0_q;
	logic [16:0]           t_q;
	logic signed [17:0]    s_q;
	logic signed [50:0]    prod_q;

	// result registers
	logic [2:0]  status_q;
	logic [31:0] rv_q;
	logic [3:0]  rc_q;

	logic [FRAME_BITS-1:0] key_frame;
	logic [FRAME_BITS-1:0] rd_frame;
	logic [31:0]           rd_value;
	logic [3:0]            rd_curve;
	logic [16:0]           ik;
	logic [CMPW-1:0]       ik_c;
	logic [CMPW-1:0]       rd_frame_c;
	logic [CW:0]           mid_sum;
	logic [CW-1:0]         mid;
	logic [CW-1:0]         last;
	logic                  crv_bad;

	logic [BW-1:0]   time_w;
	logic [BW-1:0]   base_w;
	logic [31:0]     time_gap;
	logic [31:0]     ti_a;
	logic [31:0]     ti_j;
	logic [SIN_IW-1:0] idx_a;
	logic [SIN_IW-1:0] idx_j;
	logic [16:0]     sin_a;
	logic [16:0]     sin_b;
	logic [16:0]     sin_sn;
	logic [16:0]     sin_cs;
	logic [NW-1:0]   tan_num;
	logic [NW-1:0]   div_num;
	logic [DW-1:0]   div_den;
	logic            div_busy;
	logic [NW-1:0]   div_quo;
	logic signed [17:0] s_next;
	logic signed [32:0] diff;
	logic signed [50:0] prod_rnd;
	logic signed [34:0] step_q16;
	logic signed [35:0] lerp_sum;
	logic [31:0]        lerp_val;

	// field views
	assign key_frame  = FRAME_BITS'(time_q[31:16]);
	assign rd_frame   = rd_q[EW-1 -: FRAME_BITS];
	assign rd_value   = rd_q[35:4];
	assign rd_curve   = rd_q[3:0];
	assign ik         = {1'b0, time_q[31:16]} + 17'(|time_q[15:0]);
	assign ik_c       = CMPW'(ik);
	assign rd_frame_c = CMPW'(rd_frame);
	assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q} + 1'b1;
	assign mid        = mid_sum[CW:1];
	assign last       = count_q - 1'b1;
	assign crv_bad    = crv_q > CRV_TAN;

	// status to controller
	always_comb begin
		sts.op           = op_q;
		sts.cnt_full     = (int'(count_q) >= int'(cap_q)) || (int'(count_q) >= DEPTH);
		sts.crv_bad      = crv_bad;
		sts.cnt_zero     = count_q == '0;
		sts.idx_at_count = idx_q == count_q;
		sts.scan_stop    = rd_frame >= key_frame;
		sts.hit          = hit_q;
		sts.hi_eq_idx    = hi_q == idx_q;
		sts.shd_end      = ({1'b0, idx_q} + 1'b1) >= {1'b0, count_q};
		sts.ik_before    = rd_frame_c > ik_c;
		sts.ik_after     = rd_frame_c < ik_c;
		sts.lo_eq_hi     = lo_q == hi_q;
		sts.lo_is_last   = lo_q == last;
		sts.c0_bad       = c0_q > CRV_TAN;
		sts.div_busy     = div_busy;
		sts.tan_curve    = c0_q == CRV_TAN;
	end

	// read address
	always_comb begin
		case (cmd.rd_sel)
			RD_IDX:  rd_addr_c = idx_q;
			RD_IDX1: rd_addr_c = idx_q + 1'b1;
			RD_HI1:  rd_addr_c = hi_q - 1'b1;
			RD_LO:   rd_addr_c = lo_q;
			RD_LO1:  rd_addr_c = lo_q + 1'b1;
			RD_MID:  rd_addr_c = mid;
			RD_LAST: rd_addr_c = last;
			default: rd_addr_c = '0;
		endcase
	end

	// write address and data
	always_comb begin
		wr_addr_c = (cmd.wr_sel == WR_SHIFT_HI) ? hi_q : idx_q;
		case (cmd.wr_sel)
			WR_NEW:  wr_data = {key_frame, val_q, crv_q};
			WR_SET:  wr_data = {rd_frame, (msk_q[0] ? val_q : rd_value),
			                    ((msk_q[1] && !crv_bad) ? crv_q : rd_curve)};
			default: wr_data = rd_q;
		endcase
	end

	// key memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr_c[AW-1:0]] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr_c[AW-1:0]];
		end
	end

	// control state: count, capacity, pointers, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= 7'd64;
			done_q  <= 1'b0;
			idx_q   <= '0;
			hi_q    <= '0;
			lo_q    <= '0;
			hit_q   <= 1'b0;
		end else begin
			done_q <= cmd.res_en;
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (cmd.cnt_clr) begin
				count_q <= '0;
			end else if (cmd.cnt_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.load) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.scan_cmp) begin
				hit_q <= rd_frame == key_frame;
			end
			if (cmd.hi_from_count) begin
				hi_q <= count_q;
			end else if (cmd.hi_dec) begin
				hi_q <= hi_q - 1'b1;
			end else if (cmd.bs_init) begin
				hi_q <= last;
			end else if (cmd.bs_step && !(rd_frame_c <= ik_c)) begin
				hi_q <= mid - 1'b1;
			end
			if (cmd.bs_init) begin
				lo_q <= '0;
			end else if (cmd.bs_step && (rd_frame_c <= ik_c)) begin
				lo_q <= mid;
			end
		end
	end

	// division operands: time distance over frame gap, or tangent ratio
	assign time_w   = BW'(time_q);
	assign base_w   = BW'({f0_q, 16'h0000});
	assign time_gap = (time_w > base_w) ? 32'(time_w - base_w) : 32'd0;
	assign ti_a     = 32'(t_q) * 32'(CURVE_N) + 32'd32768;
	assign ti_j     = 32'(t_q) * 32'(CURVE_N) + 32'd65536;
	assign idx_a    = SIN_IW'(ti_a >> 16);
	assign idx_j    = SIN_IW'(ti_j >> 17);
	assign sin_a    = SINE_TAB[idx_a];
	assign sin_b    = SINE_TAB[SIN_IW'(CURVE_N) - idx_a];
	assign sin_sn   = SINE_TAB[idx_j];
	assign sin_cs   = SINE_TAB[SIN_IW'(CURVE_N) - idx_j];
	assign tan_num  = {1'b0, sin_sn, 16'h0000} + NW'(sin_cs >> 1);
	assign div_num  = cmd.div_tan ? tan_num : NW'(time_gap);
	assign div_den  = cmd.div_tan ? DW'(sin_cs) : DW'(f1_q - f0_q);

	kts_div #(
		.NW(NW),
		.DW(DW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_t | cmd.div_tan),
		.num   (div_num),
		.den   (div_den),
		.busy  (div_busy),
		.quo   (div_quo)
	);

	// easing curve shaping
	always_comb begin
		case (c0_q)
			CRV_LINEAR: s_next = $signed({1'b0, t_q});
			CRV_SIN1,
			CRV_COS4:   s_next = $signed({1'b0, sin_a});
			CRV_SIN2,
			CRV_COS1:   s_next = $signed({1'b0, sin_b});
			CRV_SIN3,
			CRV_COS2:   s_next = -$signed({1'b0, sin_a});
			CRV_SIN4,
			CRV_COS3:   s_next = -$signed({1'b0, sin_b});
			default:    s_next = (sin_cs == '0) ? 18'sd65536 : $signed({1'b0, div_quo[16:0]});
		endcase
	end

	// lerp: v0 + floor((dv * s + 32768) / 65536), saturated
	assign diff     = $signed({v1_q[31], v1_q}) - $signed({v0_q[31], v0_q});
	assign prod_rnd = prod_q + 51'sd32768;
	assign step_q16 = prod_rnd[50:16];
	assign lerp_sum = $signed({{4{v0_q[31]}}, v0_q}) + $signed({step_q16[34], step_q16});
	always_comb begin
		if (lerp_sum > 36'sd2147483647) begin
			lerp_val = 32'h7FFF_FFFF;
		end else if (lerp_sum < -36'sd2147483648) begin
			lerp_val = 32'h8000_0000;
		end else begin
			lerp_val = lerp_sum[31:0];
		end
	end

	// item latch and evaluate path registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			time_q <= frame_time;
			val_q  <= value;
			crv_q  <= curve;
			msk_q  <= write_mask;
		end
		if (cmd.k0_load) begin
			f0_q <= rd_frame;
			v0_q <= rd_value;
			c0_q <= rd_curve;
		end
		if (cmd.k1_load) begin
			f1_q <= rd_frame;
			v1_q <= rd_value;
		end
		if (cmd.t_load) begin
			t_q <= (div_quo > NW'(65536)) ? 17'h10000 : div_quo[16:0];
		end
		if (cmd.s_load) begin
			s_q <= s_next;
		end
		if (cmd.mul_load) begin
			prod_q <= diff * s_q;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.res_en) begin
			rv_q <= '0;
			rc_q <= '0;
			case (cmd.res_sel)
				RES_OK:        status_q <= ST_OK;
				RES_NOT_FOUND: status_q <= ST_NOT_FOUND;
				RES_FULL:      status_q <= ST_FULL;
				RES_DUP:       status_q <= ST_DUPLICATE;
				RES_BAD:       status_q <= ST_BAD_CURVE;
				RES_OOR:       status_q <= ST_OUT_OF_RANGE;
				RES_GET: begin
					status_q <= ST_OK;
					rv_q     <= rd_value;
					rc_q     <= rd_curve;
				end
				RES_HOLD: begin
					status_q <= ST_OK;
					rv_q     <= rd_value;
				end
				RES_LERP: begin
					status_q <= ST_OK;
					rv_q     <= lerp_val;
				end
				RES_SET:  status_q <= (msk_q[1] && crv_bad) ? ST_BAD_CURVE : ST_OK;
				default:  status_q <= ST_OUT_OF_RANGE;
			endcase
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign result_value = rv_q;
	assign result_curve = rc_q;
	assign key_count    = 7'(count_q);

endmodule

@@ rtl/kts_ctrl.sv @@
// kts_ctrl: sequencer for the key track operations; issues datapath commands
// from datapath status. Depends on kts_pkg.
module kts_ctrl
	import kts_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				case (sts.op)
					OP_INSERT:   state_d = (sts.cnt_full || sts.crv_bad) ? S_IDLE : S_SCAN_ADDR;
					OP_REMOVE,
					OP_SET,
					OP_GET:      state_d = S_SCAN_ADDR;
					OP_EVALUATE: state_d = sts.cnt_zero ? S_IDLE : S_EV_FIRST_CHK;
					default:     state_d = S_IDLE;
				endcase
			end
			S_SCAN_ADDR: state_d = sts.idx_at_count ? S_ACT : S_SCAN_CMP;
			S_SCAN_CMP:  state_d = sts.scan_stop ? S_ACT : S_SCAN_ADDR;
			S_ACT: begin
				if (!sts.hit) begin
					state_d = (sts.op == OP_INSERT) ? S_SHU_RD : S_IDLE;
				end else begin
					case (sts.op)
						OP_REMOVE: state_d = S_SHD_RD;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_SHU_RD:       state_d = sts.hi_eq_idx ? S_IDLE : S_SHU_WR;
			S_SHU_WR:       state_d = S_SHU_RD;
			S_SHD_RD:       state_d = sts.shd_end ? S_IDLE : S_SHD_WR;
			S_SHD_WR:       state_d = S_SHD_RD;
			S_EV_FIRST_CHK: state_d = sts.ik_before ? S_IDLE : S_EV_LAST_CHK;
			S_EV_LAST_CHK:  state_d = sts.ik_after ? S_IDLE : S_BS_ADDR;
			S_BS_ADDR:      state_d = sts.lo_eq_hi ? S_EV_GOT0 : S_BS_CMP;
			S_BS_CMP:       state_d = S_BS_ADDR;
			S_EV_GOT0:      state_d = sts.lo_is_last ? S_IDLE : S_EV_GOT1;
			S_EV_GOT1:      state_d = sts.c0_bad ? S_IDLE : S_EV_DIVS;
			S_EV_DIVS:      state_d = S_EV_DIV;
			S_EV_DIV:       state_d = sts.div_busy ? S_EV_DIV : S_EV_SHAPE;
			S_EV_SHAPE:     state_d = sts.tan_curve ? S_EV_TDIV : S_EV_MUL;
			S_EV_TDIV:      state_d = sts.div_busy ? S_EV_TDIV : S_EV_MUL;
			S_EV_MUL:       state_d = S_EV_FIN;
			S_EV_FIN:       state_d = S_IDLE;
			default:        state_d = S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.load = start;
			S_DISPATCH: begin
				case (sts.op)
					OP_INSERT: begin
						if (sts.cnt_full) begin
							cmd.res_en  = 1'b1;
							cmd.res_sel = RES_FULL;
						end else if (sts.crv_bad) begin
							cmd.res_en  = 1'b1;
							cmd.res_sel = RES_BAD;
						end
					end
					OP_REMOVE,
					OP_SET,
					OP_GET: ;
					OP_EVALUATE: begin
						if (sts.cnt_zero) begin
							cmd.res_en  = 1'b1;
							cmd.res_sel = RES_NOT_FOUND;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_ZERO;
						end
					end
					OP_CLEAR: begin
						cmd.cnt_clr = 1'b1;
						cmd.res_en  = 1'b1;
						cmd.res_sel = RES_OK;
					end
					default: begin
						cmd.res_en  = 1'b1;
						cmd.res_sel = RES_OOR;
					end
				endcase
			end
			S_SCAN_ADDR: begin
				if (!sts.idx_at_count) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX;
				end
			end
			S_SCAN_CMP: begin
				cmd.scan_cmp = 1'b1;
				cmd.idx_inc  = !sts.scan_stop;
			end
			S_ACT: begin
				if (!sts.hit) begin
					if (sts.op == OP_INSERT) begin
						cmd.hi_from_count = 1'b1;
					end else begin
						cmd.res_en  = 1'b1;
						cmd.res_sel = RES_NOT_FOUND;
					end
				end else begin
					case (sts.op)
						OP_INSERT: begin
							cmd.res_en  = 1'b1;
							cmd.res_sel = RES_DUP;
						end
						OP_SET: begin
							cmd.wr_en   = 1'b1;
							cmd.wr_sel  = WR_SET;
							cmd.res_en  = 1'b1;
							cmd.res_sel = RES_SET;
						end
						OP_GET: begin
							cmd.res_en  = 1'b1;
							cmd.res_sel = RES_GET;
						end
						default: ;
					endcase
				end
			end
			// open a slot: move entries up from the top down to the insert point
			S_SHU_RD: begin
				if (sts.hi_eq_idx) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_sel  = WR_NEW;
					cmd.cnt_inc = 1'b1;
					cmd.res_en  = 1'b1;
					cmd.res_sel = RES_OK;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_HI1;
				end
			end
			S_SHU_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_SHIFT_HI;
				cmd.hi_dec = 1'b1;
			end
			// close the gap: move entries down above the removed key
			S_SHD_RD: begin
				if (sts.shd_end) begin
					cmd.cnt_dec = 1'b1;
					cmd.res_en  = 1'b1;
					cmd.res_sel = RES_OK;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX1;
				end
			end
			S_SHD_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_SHIFT_IDX;
				cmd.idx_inc = 1'b1;
			end
			S_EV_FIRST_CHK: begin
				if (sts.ik_before) begin
					cmd.res_en  = 1'b1;
					cmd.res_sel = RES_OOR;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_LAST;
				end
			end
			S_EV_LAST_CHK: begin
				if (sts.ik_after) begin
					cmd.res_en  = 1'b1;
					cmd.res_sel = RES_OOR;
				end else begin
					cmd.bs_init = 1'b1;
				end
			end
			// binary search for the last key at or before the frame time rounded up to a whole frame
			S_BS_ADDR: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = sts.lo_eq_hi ? RD_LO : RD_MID;
			end
			S_BS_CMP: cmd.bs_step = 1'b1;
			S_EV_GOT0: begin
				if (sts.lo_is_last) begin
					cmd.res_en  = 1'b1;
					cmd.res_sel = RES_HOLD;
				end else begin
					cmd.k0_load = 1'b1;
					cmd.rd_en   = 1'b1;
					cmd.rd_sel  = RD_LO1;
				end
			end
			S_EV_GOT1: begin
				cmd.k1_load = 1'b1;
				if (sts.c0_bad) begin
					cmd.res_en  = 1'b1;
					cmd.res_sel = RES_BAD;
				end
			end
			S_EV_DIVS: cmd.div_t = 1'b1;
			S_EV_DIV:  cmd.t_load = !sts.div_busy;
			S_EV_SHAPE: begin
				if (sts.tan_curve) begin
					cmd.div_tan = 1'b1;
				end else begin
					cmd.s_load = 1'b1;
				end
			end
			S_EV_TDIV: cmd.s_load = !sts.div_busy;
			S_EV_MUL:  cmd.mul_load = 1'b1;
			S_EV_FIN: begin
				cmd.res_en  = 1'b1;
				cmd.res_sel = RES_LERP;
			end
			default: ;
		endcase
	end

	assign busy = state_q != S_IDLE;

endmodule

@@ rtl/keyframe_track_store_sampler.sv @@
// Sorted animation key table with insert, remove, set, get, clear and
// evaluate. An item is taken when start is high and busy is low; busy stays
// high until the result is formed, and the result is shown for exactly one
// cycle with done high, with no way for the receiver to hold it off. All
// work runs through one key memory (one read port, one write port), so
// the latency is set by memory accesses: clear and unknown operations
// finish at dispatch; get, set and remove scan the keys one at a time and
// remove then moves each later key down one place; insert scans the same
// way and moves each later key up, so an insert costs about the same
// wherever the new key lands.
// Evaluate runs a binary search and then a serial division, and a second
// serial division for the tangent curve; it ends sooner when it holds the
// last key or refuses the time. The key memory needs no clearing after reset.
// Depends on kts_pkg, kts_ctrl, kts_datapath, kts_div.
module keyframe_track_store_sampler
	import kts_pkg::*;
#(
	parameter int DEPTH      = 64,
	parameter int FRAME_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         operation,
	input  logic [31:0]        frame_time,
	input  logic signed [31:0] value,
	input  logic [3:0]         curve,
	input  logic [1:0]         write_mask,
	input  logic               cfg_wr_en,
	input  logic [6:0]         cfg_wr_data,
	output logic               done,
	output logic [2:0]         status,
	output logic signed [31:0] result_value,
	output logic [3:0]         result_curve,
	output logic [6:0]         key_count
);

	cmd_t cmd;
	sts_t sts;

	kts_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	kts_datapath #(
		.DEPTH     (DEPTH),
		.FRAME_BITS(FRAME_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.operation   (operation),
		.frame_time  (frame_time),
		.value       (value),
		.curve       (curve),
		.write_mask  (write_mask),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.done        (done),
		.status      (status),
		.result_value(result_value),
		.result_curve(result_curve),
		.key_count   (key_count)
	);

endmodule
